// ===== src/bfc_pkg.sv =====
package bfc_pkg;

    // Graph size and edge multiplicity width
    localparam int LEFT_VERTICES  = 64;
    localparam int RIGHT_VERTICES = 64;
    localparam int MULT_WIDTH     = 16;

    // Field widths of the stream items
    localparam int OP_W     = 2;
    localparam int VIN_W    = 6;
    localparam int BF_W     = 17;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Derived storage widths
    localparam int LW      = $clog2(LEFT_VERTICES);
    localparam int RW      = (RIGHT_VERTICES > 1) ? $clog2(RIGHT_VERTICES) : 1;
    localparam int CN_W    = $clog2(RIGHT_VERTICES + 1);
    localparam int WCNT_W  = $clog2(LEFT_VERTICES + 1);
    localparam int EDGE_AW = LW + RW;
    localparam int PAIR_AW = 2 * LW;
    localparam int EDGE_DEPTH = 2 ** EDGE_AW;
    localparam int PAIR_DEPTH = 2 ** PAIR_AW;
    localparam int CLR_DEPTH  = (EDGE_DEPTH > PAIR_DEPTH) ? EDGE_DEPTH : PAIR_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    localparam logic [MULT_WIDTH-1:0] MULT_MAX = '1;
    localparam logic [BF_W-1:0]       BF_MAX   = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT    = 2'd2;

endpackage

// ===== src/bipartite_butterfly_count_update.sv =====
// Butterfly counter for a bipartite multigraph. Each input transfer carries
// an operation (insert edge, remove edge, query; code three acts as query),
// a left vertex and a right vertex; each produces exactly one result
// transfer with the left vertex's butterfly count after the operation and a
// status (ok, removal of an absent edge ignored, multiplicity saturated and
// insert ignored). Edge multiplicities and common-neighbour counts live in
// RAMs; per-vertex counts live in a small RAM. After reset the block runs a
// clearing pass over the larger RAM depth with s_tready low. Queries and
// edge changes that keep adjacency pass through the read, decide and done
// states before the result is registered. An edge change that creates or
// removes adjacency walks every left vertex, one per cycle through a single
// saturating update unit that shares the RAM read/write ports, then writes
// back the item's own count. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
module bipartite_butterfly_count_update (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] operation, [7:2] left_vertex, [13:8] right_vertex, [15:14] zero
    input  logic [bfc_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [16:0] butterfly_total, [18:17] status, [23:19] zero
    output logic [bfc_pkg::M_DATA_W-1:0]   m_tdata
);
    import bfc_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_WB     = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [WCNT_W-1:0] w_cnt_reg, w_cnt_next;
    logic p_valid_reg, p_valid_next;
    logic [LW-1:0] p_w_reg, p_w_next;

    // Item being worked on
    logic [OP_W-1:0]  op_reg, op_next;
    logic [VIN_W-1:0] u_in_reg, u_in_next;
    logic [VIN_W-1:0] v_in_reg, v_in_next;
    logic [BF_W-1:0]  bfu_reg, bfu_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [LW-1:0] u_idx, w_idx;
    logic [RW-1:0] v_idx;
    logic u_ok, v_ok, is_remove;

    // RAM ports
    logic                  edge_we, pair_we, bf_we;
    logic [EDGE_AW-1:0]    edge_wa, edge_ra;
    logic [PAIR_AW-1:0]    pair_wa, pair_ra;
    logic [LW-1:0]         bf_wa, bf_ra;
    logic [MULT_WIDTH-1:0] edge_wd, edge_rd;
    logic [CN_W-1:0]       pair_wd, pair_rd;
    logic [BF_W-1:0]       bf_wd, bf_rd;

    logic            stage_active;
    logic [CN_W-1:0] cn_new;
    logic [BF_W-1:0] bfu_upd, bfw_upd;

    function automatic logic [PAIR_AW-1:0] pair_addr(logic [LW-1:0] a, logic [LW-1:0] b);
        // common counts are symmetric: keep one entry per unordered pair
        pair_addr = (a < b) ? {a, b} : {b, a};
    endfunction

    assign u_idx = LW'(u_in_reg);
    assign v_idx = RW'(v_in_reg);
    assign w_idx = w_cnt_reg[LW-1:0];
    assign u_ok  = {{(32 - VIN_W){1'b0}}, u_in_reg} < 32'(LEFT_VERTICES);
    assign v_ok  = {{(32 - VIN_W){1'b0}}, v_in_reg} < 32'(RIGHT_VERTICES);
    assign is_remove = (op_reg == OP_REMOVE);

    // Walk stage: data read last cycle for vertex p_w
    assign stage_active = (state_reg == ST_WALK) && p_valid_reg && (p_w_reg != u_idx)
                          && (edge_rd != '0);

    bfc_ram #(.WIDTH(MULT_WIDTH), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (edge_we),
        .wr_addr (edge_wa),
        .wr_data (edge_wd),
        .rd_addr (edge_ra),
        .rd_data (edge_rd)
    );

    bfc_ram #(.WIDTH(CN_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
        .aclk    (aclk),
        .wr_en   (pair_we),
        .wr_addr (pair_wa),
        .wr_data (pair_wd),
        .rd_addr (pair_ra),
        .rd_data (pair_rd)
    );

    bfc_ram #(.WIDTH(BF_W), .DEPTH(2 ** LW)) u_bf_ram (
        .aclk    (aclk),
        .wr_en   (bf_we),
        .wr_addr (bf_wa),
        .wr_data (bf_wd),
        .rd_addr (bf_ra),
        .rd_data (bf_rd)
    );

    bfc_upd_unit u_upd (
        .is_remove (is_remove),
        .cn_in     (pair_rd),
        .bf_a      (bfu_reg),
        .bf_b      (bf_rd),
        .cn_out    (cn_new),
        .bf_a_out  (bfu_upd),
        .bf_b_out  (bfw_upd)
    );

    // Read addresses: the item's own entries while fetching, else the walk
    always_comb begin
        if (state_reg == ST_WALK) begin
            edge_ra = {w_idx, v_idx};
            bf_ra   = w_idx;
        end else begin
            edge_ra = {u_idx, v_idx};
            bf_ra   = u_idx;
        end
        pair_ra = pair_addr(u_idx, w_idx);
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        w_cnt_next    = w_cnt_reg;
        p_valid_next  = 1'b0;
        p_w_next      = p_w_reg;
        op_next       = op_reg;
        u_in_next     = u_in_reg;
        v_in_next     = v_in_reg;
        bfu_next      = bfu_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        edge_we = 1'b0;
        edge_wa = {u_idx, v_idx};
        edge_wd = edge_rd;
        pair_we = 1'b0;
        pair_wa = pair_addr(u_idx, p_w_reg);
        pair_wd = cn_new;
        bf_we   = 1'b0;
        bf_wa   = p_w_reg;
        bf_wd   = bfw_upd;

        unique case (state_reg)
            ST_CLEAR: begin
                // zero every RAM entry, one address a cycle
                edge_we = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(EDGE_DEPTH);
                edge_wa = clr_cnt_reg[EDGE_AW-1:0];
                edge_wd = '0;
                pair_we = {1'b0, clr_cnt_reg} < (CLR_W + 1)'(PAIR_DEPTH);
                pair_wa = clr_cnt_reg[PAIR_AW-1:0];
                pair_wd = '0;
                bf_we   = 1'b1;
                bf_wa   = clr_cnt_reg[LW-1:0];
                bf_wd   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[1:0];
                    u_in_next  = s_tdata[7:2];
                    v_in_next  = s_tdata[13:8];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                bfu_next   = bf_rd;
                stat_next  = STAT_OK;
                w_cnt_next = '0;
                state_next = ST_DONE;
                if (u_ok && v_ok && op_reg == OP_INSERT) begin
                    if (edge_rd == MULT_MAX) begin
                        stat_next = STAT_SAT;
                    end else begin
                        edge_we = 1'b1;
                        edge_wd = edge_rd + 1'b1;
                        if (edge_rd == '0) begin
                            state_next = ST_WALK;
                        end
                    end
                end else if (u_ok && v_ok && op_reg == OP_REMOVE) begin
                    if (edge_rd == '0) begin
                        stat_next = STAT_ABSENT;
                    end else begin
                        edge_we = 1'b1;
                        edge_wd = edge_rd - 1'b1;
                        if (edge_rd == MULT_WIDTH'(1)) begin
                            state_next = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                // issue reads for the next vertex, update the one read last cycle
                if (w_cnt_reg < WCNT_W'(LEFT_VERTICES)) begin
                    w_cnt_next   = w_cnt_reg + 1'b1;
                    p_valid_next = 1'b1;
                    p_w_next     = w_idx;
                end else if (!p_valid_reg) begin
                    state_next = ST_WB;
                end
                if (stage_active) begin
                    pair_we  = 1'b1;
                    bf_we    = 1'b1;
                    bfu_next = bfu_upd;
                end
            end
            ST_WB: begin
                bf_we      = 1'b1;
                bf_wa      = u_idx;
                bf_wd      = bfu_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W - BF_W - STAT_W){1'b0}}, stat_reg,
                                     (u_ok ? bfu_reg : {BF_W{1'b0}})};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            w_cnt_reg    <= '0;
            p_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            w_cnt_reg    <= w_cnt_next;
            p_valid_reg  <= p_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_w_reg     <= p_w_next;
        op_reg      <= op_next;
        u_in_reg    <= u_in_next;
        v_in_reg    <= v_in_next;
        bfu_reg     <= bfu_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/bfc_ram.sv =====
module bfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/bfc_upd_unit.sv =====
module bfc_upd_unit (
    input  logic                      is_remove,
    input  logic [bfc_pkg::CN_W-1:0]  cn_in,
    input  logic [bfc_pkg::BF_W-1:0]  bf_a,
    input  logic [bfc_pkg::BF_W-1:0]  bf_b,
    output logic [bfc_pkg::CN_W-1:0]  cn_out,
    output logic [bfc_pkg::BF_W-1:0]  bf_a_out,
    output logic [bfc_pkg::BF_W-1:0]  bf_b_out
);
    import bfc_pkg::*;

    logic [CN_W-1:0] delta;

    function automatic logic [BF_W-1:0] sat_add(logic [BF_W-1:0] bf, logic [CN_W-1:0] d);
        logic [BF_W:0] s;
        s = {1'b0, bf} + (BF_W + 1)'(d);
        sat_add = (s > {1'b0, BF_MAX}) ? BF_MAX : s[BF_W-1:0];
    endfunction

    function automatic logic [BF_W-1:0] sat_sub(logic [BF_W-1:0] bf, logic [CN_W-1:0] d);
        sat_sub = (BF_W'(d) >= bf) ? '0 : bf - BF_W'(d);
    endfunction

    // Insert: move by the count before the increase; remove: after the decrease
    always_comb begin
        if (is_remove) begin
            cn_out   = (cn_in != '0) ? cn_in - 1'b1 : '0;
            delta    = cn_out;
            bf_a_out = sat_sub(bf_a, delta);
            bf_b_out = sat_sub(bf_b, delta);
        end else begin
            cn_out   = cn_in + 1'b1;
            delta    = cn_in;
            bf_a_out = sat_add(bf_a, delta);
            bf_b_out = sat_add(bf_b, delta);
        end
    end

endmodule
